// ===== hw/rtl/sap_pkg.sv =====
// Shared types and constants for the servo angle-to-pulse block.
// Used by sap_div and servo_angle_to_pulse; no dependencies.
package sap_pkg;

    localparam int MAX_SERVOS_DEF = 16;
    localparam int DATA_W         = 16;
    localparam int CNT_W          = 5;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;

    localparam logic [DATA_W-1:0] PWM_PERIOD_RST = 16'd20000;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_COUNT = 1'b1;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_ANGLE = 2'd1,
        FUNC_PULSE = 2'd2,
        FUNC_HOME  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_REVERSED = 2'd3
    } status_t;

    typedef struct packed {
        func_t       func;
        logic [3:0]  servo_index;
        logic [15:0] angle;
        logic [15:0] pulse_request;
        logic [15:0] entry_min_angle;
        logic [15:0] entry_max_angle;
        logic [15:0] entry_min_pulse;
        logic [15:0] entry_max_pulse;
        logic [3:0]  entry_channel;
        logic        entry_inverted;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic        apply;
        logic [3:0]  target_index;
        logic [3:0]  out_channel;
        logic [15:0] pulse_width;
        logic [15:0] period;
        logic        invert_polarity;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [15:0] amin;
        logic [15:0] amax;
        logic [15:0] pmin;
        logic [15:0] pmax;
        logic [3:0]  channel;
        logic        inverted;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [DATA_W-1:0] clamp16(input logic [DATA_W-1:0] v,
                                                  input logic [DATA_W-1:0] lo,
                                                  input logic [DATA_W-1:0] hi);
        logic [DATA_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sap_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on sap_pkg (DATA_W, div_stat_t).
module sap_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [2*sap_pkg::DATA_W-1:0]   dividend,
    input  logic [sap_pkg::DATA_W-1:0]     divisor,
    output sap_pkg::div_stat_t             stat,
    output logic [sap_pkg::DATA_W-1:0]     quotient
);

    localparam int DW     = sap_pkg::DATA_W;
    localparam int STEP_W = $clog2(DW + 1);

    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     quo_reg;
    logic [DW-1:0]     dsr_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DW:0] shifted;
    logic [DW:0] trial;
    logic        take;

    // caller guarantees dividend high half < divisor, so quotient fits DW bits
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign take    = ~trial[DW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[2*DW-1:DW];
            quo_reg <= dividend[DW-1:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? trial[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], take};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== hw/rtl/servo_angle_to_pulse.sv =====
// Servo table and command sequencer: maps angles or raw pulses to PWM drive commands.
// Depends on sap_pkg and sap_div.
//
//  channel | signals                        | direction | flow control
//  --------+--------------------------------+-----------+-------------
//  command | cmd_valid, cmd_stall, cmd      | in        | cmd_stall
//  result  | rsp_valid, rsp_stall, rsp      | out       | rsp_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in | cfg_ready (always 1)
//
// Write entry, set pulse and error results: ST_EXEC after transfer, then result in ST_OUT.
// Set angle: table read, multiply into divider, 16 divider steps, capture, output.
// Home all: set-angle steps for each active servo, plus any result-side stalls.
// One command at a time; cmd_stall stays high until its last result is transferred.
// Reset clears table, state, cursor and servo count at once; no clearing pass.
module servo_angle_to_pulse #(
    parameter int MAX_SERVOS = sap_pkg::MAX_SERVOS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  sap_pkg::cmd_t                     cmd,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output sap_pkg::rsp_t                     rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sap_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int TBL_DEPTH = (MAX_SERVOS < 16) ? MAX_SERVOS : 16;
    localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int CMP_W     = 8;
    localparam int CW        = sap_pkg::CNT_W;
    localparam int DW        = sap_pkg::DATA_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    sap_pkg::cmd_t      cmd_reg;
    logic [CW-1:0]      cursor_reg, cursor_next;
    sap_pkg::entry_t    ent_reg, ent_next;
    logic [DW-1:0]      diff_reg, diff_next;
    logic [DW-1:0]      arange_reg, arange_next;
    logic [DW-1:0]      prange_reg, prange_next;
    sap_pkg::rsp_t      rsp_reg, rsp_next;
    sap_pkg::entry_t    tbl_reg [TBL_DEPTH];
    logic [DW-1:0]      pwm_period_reg;
    logic [CW-1:0]      servo_count_reg;

    logic               cmd_accept;
    logic               tbl_we;
    sap_pkg::entry_t    wr_ent;
    logic [IDX_W-1:0]   rd_addr;
    sap_pkg::entry_t    rd_ent;
    logic               is_home;
    logic [3:0]         cur_idx;
    logic [CW-1:0]      n_active;
    logic               in_range;
    logic               wr_idx_ok;
    logic [DW-1:0]      a_req;
    logic [DW-1:0]      ca;
    logic               last_ok;
    logic [DW:0]        pulse_sum;
    logic [DW-1:0]      pulse_div;
    logic [2*DW-1:0]    product;
    logic               div_start;
    sap_pkg::div_stat_t div_stat;
    logic [DW-1:0]      quotient;

    assign cmd_accept = cmd_valid && (state_reg == ST_IDLE);
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = (state_reg == ST_OUT);
    assign rsp        = rsp_reg;
    assign cfg_ready  = 1'b1;

    assign n_active  = (servo_count_reg > CW'(TBL_DEPTH)) ? CW'(TBL_DEPTH) : servo_count_reg;
    assign is_home   = (cmd_reg.func == sap_pkg::FUNC_HOME);
    assign cur_idx   = is_home ? cursor_reg[3:0] : cmd_reg.servo_index;
    assign rd_addr   = is_home ? cursor_reg[IDX_W-1:0] : cmd_reg.servo_index[IDX_W-1:0];
    assign rd_ent    = tbl_reg[rd_addr];
    assign in_range  = {1'b0, cmd_reg.servo_index} < n_active;
    assign wr_idx_ok = CMP_W'(cmd_reg.servo_index) < CMP_W'(MAX_SERVOS);
    assign a_req     = is_home ? rd_ent.amin : cmd_reg.angle;
    assign ca        = sap_pkg::clamp16(a_req, rd_ent.amin, rd_ent.amax);
    assign last_ok   = !is_home || (cursor_reg == (n_active - CW'(1)));
    assign pulse_sum = {1'b0, ent_reg.pmin} + {1'b0, quotient};
    assign pulse_div = sap_pkg::clamp16(pulse_sum[DW-1:0], ent_reg.pmin, ent_reg.pmax);
    assign product   = diff_reg * prange_reg;
    assign div_start = (state_reg == ST_LOAD);

    assign wr_ent.amin     = cmd_reg.entry_min_angle;
    assign wr_ent.amax     = cmd_reg.entry_max_angle;
    assign wr_ent.pmin     = cmd_reg.entry_min_pulse;
    assign wr_ent.pmax     = cmd_reg.entry_max_pulse;
    assign wr_ent.channel  = cmd_reg.entry_channel;
    assign wr_ent.inverted = cmd_reg.entry_inverted;

    sap_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (arange_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        ent_next    = ent_reg;
        diff_next   = diff_reg;
        arange_next = arange_reg;
        prange_next = prange_reg;
        rsp_next    = rsp_reg;
        tbl_we      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    cursor_next = '0;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rsp_next              = '0;
                rsp_next.target_index = cur_idx;
                rsp_next.last         = 1'b1;
                state_next            = ST_OUT;
                case (cmd_reg.func)
                    sap_pkg::FUNC_WRITE:
                    begin
                        if (!wr_idx_ok)
                        begin
                            rsp_next.status = sap_pkg::STAT_RANGE;
                        end
                        else if (wr_ent.amin > wr_ent.amax || wr_ent.pmin > wr_ent.pmax)
                        begin
                            rsp_next.status = sap_pkg::STAT_REVERSED;
                        end
                        else
                        begin
                            tbl_we = 1'b1;
                        end
                    end
                    sap_pkg::FUNC_PULSE:
                    begin
                        if (!in_range)
                        begin
                            rsp_next.status = sap_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            rsp_next.apply           = 1'b1;
                            rsp_next.out_channel     = rd_ent.channel;
                            rsp_next.pulse_width     = sap_pkg::clamp16(cmd_reg.pulse_request,
                                                                        rd_ent.pmin, rd_ent.pmax);
                            rsp_next.period          = pwm_period_reg;
                            rsp_next.invert_polarity = rd_ent.inverted;
                        end
                    end
                    sap_pkg::FUNC_ANGLE, sap_pkg::FUNC_HOME:
                    begin
                        if (!is_home && !in_range)
                        begin
                            rsp_next.status = sap_pkg::STAT_RANGE;
                        end
                        else if (is_home && n_active == '0)
                        begin
                            rsp_next.status = sap_pkg::STAT_OK;
                        end
                        else if (rd_ent.amax <= rd_ent.amin)
                        begin
                            rsp_next.status = sap_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            // quotient <= prange since ca - amin <= arange
                            ent_next    = rd_ent;
                            diff_next   = ca - rd_ent.amin;
                            arange_next = rd_ent.amax - rd_ent.amin;
                            prange_next = (rd_ent.pmax >= rd_ent.pmin) ?
                                          (rd_ent.pmax - rd_ent.pmin) : '0;
                            state_next  = ST_LOAD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    rsp_next.status          = sap_pkg::STAT_OK;
                    rsp_next.apply           = 1'b1;
                    rsp_next.target_index    = cur_idx;
                    rsp_next.out_channel     = ent_reg.channel;
                    rsp_next.pulse_width     = pulse_div;
                    rsp_next.period          = pwm_period_reg;
                    rsp_next.invert_polarity = ent_reg.inverted;
                    rsp_next.last            = last_ok;
                    state_next               = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    if (!rsp_reg.last)
                    begin
                        cursor_next = cursor_reg + CW'(1);
                        state_next  = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            cmd_reg <= cmd;
        end
        ent_reg    <= ent_next;
        diff_reg   <= diff_next;
        arange_reg <= arange_next;
        prange_reg <= prange_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else if (tbl_we)
        begin
            tbl_reg[cmd_reg.servo_index[IDX_W-1:0]] <= wr_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg  <= sap_pkg::PWM_PERIOD_RST;
            servo_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sap_pkg::CFG_PWM_PERIOD:  pwm_period_reg  <= cfg_data;
                sap_pkg::CFG_SERVO_COUNT: servo_count_reg <= cfg_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("divider idle while sequencer waits on it");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_apply_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.apply) |-> (rsp.status == sap_pkg::STAT_OK))
        else $error("drive command carries an error status");

    a_noapply_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.apply) |->
        (rsp.pulse_width == '0 && rsp.period == '0 && rsp.out_channel == '0))
        else $error("non-drive result carries command fields");

    a_more_only_home: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.last) |-> (cmd_reg.func == sap_pkg::FUNC_HOME))
        else $error("multi-result sequence from a single-result command");
`endif

endmodule

// ===== tb/tb_servo_angle_to_pulse.sv =====
// Self-checking testbench for servo_angle_to_pulse: directed and random commands,
// with result prediction and randomized command gaps and result stalls.
// Depends on sap_pkg and the servo_angle_to_pulse RTL.
module tb_servo_angle_to_pulse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned TAIL_CYCLES = 40;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cmd_valid = 1'b0;
    logic                           cmd_stall;
    sap_pkg::cmd_t                  cmd       = '0;
    logic                           rsp_valid;
    logic                           rsp_stall = 1'b0;
    sap_pkg::rsp_t                  rsp;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sap_pkg::CFG_IDX_W-1:0]  cfg_index = sap_pkg::CFG_PWM_PERIOD;
    logic [sap_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted block state
    sap_pkg::entry_t servo_tbl [sap_pkg::MAX_SERVOS_DEF];
    logic [15:0]     period_cfg;
    logic [4:0]      count_cfg;
    sap_pkg::rsp_t   expected_rsp [$];

    bit          cmd_gaps_on   = 1'b0;
    bit          rsp_stalls_on = 1'b0;
    int unsigned stall_left    = 0;
    int unsigned stall_draw;
    int unsigned cycle_count     = 0;
    int unsigned fail_count      = 0;
    int unsigned results_checked = 0;
    int unsigned cmds_sent       = 0;
    int unsigned cfg_writes      = 0;
    int unsigned func_seen [4]   = '{0, 0, 0, 0};

    servo_angle_to_pulse i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic int unsigned live_servos();
        int unsigned n;
        n = count_cfg;
        if (n > sap_pkg::MAX_SERVOS_DEF)
        begin
            n = sap_pkg::MAX_SERVOS_DEF;
        end
        return n;
    endfunction

    function automatic sap_pkg::rsp_t idle_rsp(sap_pkg::status_t st, logic [3:0] idx);
        sap_pkg::rsp_t r;
        r              = '0;
        r.status       = st;
        r.target_index = idx;
        return r;
    endfunction

    function automatic sap_pkg::rsp_t pulse_rsp(int idx, logic [31:0] p);
        sap_pkg::rsp_t   r;
        sap_pkg::entry_t e;
        e                 = servo_tbl[idx];
        r                 = '0;
        r.status          = sap_pkg::STAT_OK;
        r.apply           = 1'b1;
        r.target_index    = 4'(idx);
        r.out_channel     = e.channel;
        r.pulse_width     = (p < e.pmin) ? e.pmin : ((p > e.pmax) ? e.pmax : p[15:0]);
        r.period          = period_cfg;
        r.invert_polarity = e.inverted;
        return r;
    endfunction

    function automatic sap_pkg::rsp_t angle_rsp(int idx, logic [15:0] a);
        sap_pkg::entry_t e;
        logic [15:0]     ca;
        longint unsigned da, dr, span;
        e = servo_tbl[idx];
        if (e.amax <= e.amin)
        begin
            return idle_rsp(sap_pkg::STAT_EMPTY, 4'(idx));
        end
        ca   = (a < e.amin) ? e.amin : ((a > e.amax) ? e.amax : a);
        da   = ca - e.amin;
        dr   = e.amax - e.amin;
        span = (e.pmax >= e.pmin) ? (e.pmax - e.pmin) : 0;
        return pulse_rsp(idx, 32'(e.pmin + (da * span) / dr));
    endfunction

    function automatic void push_rsp(sap_pkg::rsp_t r, bit is_last);
        r.last = is_last;
        expected_rsp.push_back(r);
    endfunction

    function automatic void predict_cmd(sap_pkg::cmd_t c);
        int unsigned   n;
        sap_pkg::rsp_t r;
        n = live_servos();
        case (c.func)
            sap_pkg::FUNC_WRITE:
            begin
                // a 4-bit index is always below the table depth, so no range error here
                if (c.entry_min_angle > c.entry_max_angle
                    || c.entry_min_pulse > c.entry_max_pulse)
                begin
                    push_rsp(idle_rsp(sap_pkg::STAT_REVERSED, c.servo_index), 1'b1);
                end
                else
                begin
                    servo_tbl[c.servo_index] = '{amin: c.entry_min_angle,
                                                 amax: c.entry_max_angle,
                                                 pmin: c.entry_min_pulse,
                                                 pmax: c.entry_max_pulse,
                                                 channel: c.entry_channel,
                                                 inverted: c.entry_inverted};
                    push_rsp(idle_rsp(sap_pkg::STAT_OK, c.servo_index), 1'b1);
                end
            end
            sap_pkg::FUNC_ANGLE, sap_pkg::FUNC_PULSE:
            begin
                if (c.servo_index >= n)
                begin
                    push_rsp(idle_rsp(sap_pkg::STAT_RANGE, c.servo_index), 1'b1);
                end
                else if (c.func == sap_pkg::FUNC_ANGLE)
                begin
                    push_rsp(angle_rsp(c.servo_index, c.angle), 1'b1);
                end
                else
                begin
                    push_rsp(pulse_rsp(c.servo_index, 32'(c.pulse_request)), 1'b1);
                end
            end
            default:
            begin
                if (n == 0)
                begin
                    push_rsp(idle_rsp(sap_pkg::STAT_OK, 4'd0), 1'b1);
                end
                else
                begin
                    // home sequence stops at the first failing entry
                    for (int i = 0; i < n; i++)
                    begin
                        r = angle_rsp(i, servo_tbl[i].amin);
                        push_rsp(r, (r.status != sap_pkg::STAT_OK) || (i == n - 1));
                        if (r.status != sap_pkg::STAT_OK)
                        begin
                            break;
                        end
                    end
                end
            end
        endcase
    endfunction

    // ---------------- checking ----------------

    function automatic string rsp_str(sap_pkg::rsp_t r);
        return $sformatf("st=%0d apply=%0d idx=%0d ch=%0d pw=%0d per=%0d inv=%0d last=%0d",
                         r.status, r.apply, r.target_index, r.out_channel, r.pulse_width,
                         r.period, r.invert_polarity, r.last);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        sap_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                note_failure({"result with nothing pending: ", rsp_str(rsp)});
            end
            else
            begin
                want = expected_rsp.pop_front();
                results_checked++;
                if (rsp.status !== want.status || rsp.apply !== want.apply
                    || rsp.target_index !== want.target_index
                    || rsp.out_channel !== want.out_channel
                    || rsp.pulse_width !== want.pulse_width
                    || rsp.period !== want.period
                    || rsp.invert_polarity !== want.invert_polarity
                    || rsp.last !== want.last)
                begin
                    note_failure({"expected ", rsp_str(want), " got ", rsp_str(rsp)});
                end
            end
        end
    end

    // result side: after each transfer, if stalls are enabled, hold stall for a random number of cycles
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            stall_draw = rsp_stalls_on ? $urandom_range(0, 13) : 0;
            stall_left <= stall_draw;
            rsp_stall  <= (stall_draw != 0);
        end
        else if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            rsp_stall  <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d, %0d results outstanding",
                     cycle_count, expected_rsp.size());
            $display("servo_angle_to_pulse regression: fail");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic sap_pkg::cmd_t noise_cmd();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return sap_pkg::cmd_t'(raw[$bits(sap_pkg::cmd_t)-1:0]);
    endfunction

    // valid stays high across back-to-back transfers; only lowered for a gap or while draining results
    task automatic send_cmd(sap_pkg::cmd_t c);
        int unsigned gap;
        gap = cmd_gaps_on ? $urandom_range(0, 13) : 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        predict_cmd(c);
        cmds_sent++;
        func_seen[c.func]++;
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_cfg(logic [sap_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == sap_pkg::CFG_PWM_PERIOD)
        begin
            period_cfg = data;
        end
        else
        begin
            count_cfg = data[4:0];
        end
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic write_entry(int idx, logic [15:0] amin, logic [15:0] amax,
                               logic [15:0] pmin, logic [15:0] pmax,
                               logic [3:0] ch, logic inv);
        sap_pkg::cmd_t c;
        c                 = noise_cmd();
        c.func            = sap_pkg::FUNC_WRITE;
        c.servo_index     = 4'(idx);
        c.entry_min_angle = amin;
        c.entry_max_angle = amax;
        c.entry_min_pulse = pmin;
        c.entry_max_pulse = pmax;
        c.entry_channel   = ch;
        c.entry_inverted  = inv;
        send_cmd(c);
    endtask

    task automatic set_angle(int idx, logic [15:0] a);
        sap_pkg::cmd_t c;
        c             = noise_cmd();
        c.func        = sap_pkg::FUNC_ANGLE;
        c.servo_index = 4'(idx);
        c.angle       = a;
        send_cmd(c);
    endtask

    task automatic set_pulse(int idx, logic [15:0] p);
        sap_pkg::cmd_t c;
        c               = noise_cmd();
        c.func          = sap_pkg::FUNC_PULSE;
        c.servo_index   = 4'(idx);
        c.pulse_request = p;
        send_cmd(c);
    endtask

    task automatic home_all();
        sap_pkg::cmd_t c;
        c      = noise_cmd();
        c.func = sap_pkg::FUNC_HOME;
        send_cmd(c);
    endtask

    // fill_idx >= 0 forces a well-formed entry write to that slot
    task automatic send_random_cmd(int fill_idx);
        sap_pkg::cmd_t   c;
        sap_pkg::entry_t e;
        int unsigned     n, pick, span;
        logic [15:0]     x, y;
        c    = noise_cmd();
        n    = live_servos();
        pick = (fill_idx >= 0) ? 0 : $urandom_range(0, 99);
        if (pick < 30)
        begin
            c.func = sap_pkg::FUNC_WRITE;
            if (fill_idx >= 0)
            begin
                c.servo_index = 4'(fill_idx);
            end
            x = 16'($urandom);
            y = 16'($urandom);
            c.entry_min_angle = (x < y) ? x : y;
            c.entry_max_angle = (x < y) ? y : x;
            x = 16'($urandom);
            y = 16'($urandom);
            c.entry_min_pulse = (x < y) ? x : y;
            c.entry_max_pulse = (x < y) ? y : x;
            if (fill_idx < 0)
            begin
                case ($urandom_range(0, 9))
                    0: {c.entry_min_angle, c.entry_max_angle} =
                           {c.entry_max_angle, c.entry_min_angle};
                    1: {c.entry_min_pulse, c.entry_max_pulse} =
                           {c.entry_max_pulse, c.entry_min_pulse};
                    2: c.entry_max_angle = c.entry_min_angle;
                    default: ;
                endcase
            end
        end
        else
        begin
            if (n != 0 && $urandom_range(0, 7) != 0)
            begin
                c.servo_index = 4'($urandom_range(0, n - 1));
            end
            e = servo_tbl[c.servo_index];
            if (pick < 65)
            begin
                c.func = sap_pkg::FUNC_ANGLE;
                if ($urandom_range(0, 2) != 0)
                begin
                    span    = e.amax - e.amin + 1;
                    c.angle = 16'(e.amin + $urandom % span);
                end
            end
            else if (pick < 90)
            begin
                c.func = sap_pkg::FUNC_PULSE;
                if ($urandom_range(0, 2) != 0)
                begin
                    span            = e.pmax - e.pmin + 1;
                    c.pulse_request = 16'(e.pmin + $urandom % span);
                end
            end
            else
            begin
                c.func = sap_pkg::FUNC_HOME;
            end
        end
        send_random_cmd_done: send_cmd(c);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_state();
        home_all();
        set_angle(0, 16'd90);
        write_cfg(sap_pkg::CFG_SERVO_COUNT, 16'd1);
        set_pulse(0, 16'hFFFF);
        set_angle(0, 16'd0);
        home_all();
        drain_results();
    endtask

    task automatic test_entry_limits();
        write_cfg(sap_pkg::CFG_SERVO_COUNT, 16'd16);
        write_cfg(sap_pkg::CFG_PWM_PERIOD, 16'hFFFF);
        cmd_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        write_entry(0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 4'hF, 1'b1);
        set_angle(0, 16'd0);
        set_angle(0, 16'hFFFF);
        set_angle(0, 16'h8000);
        // equal angle limits are stored but cannot be mapped
        write_entry(1, 16'd10, 16'd10, 16'd1000, 16'd2000, 4'd1, 1'b0);
        set_angle(1, 16'd10);
        set_pulse(1, 16'd500);
        set_pulse(1, 16'hFFFF);
        write_entry(2, 16'd100, 16'd50, 16'd500, 16'd2500, 4'd7, 1'b0);
        write_entry(2, 16'd0, 16'd180, 16'd1000, 16'd999, 4'd7, 1'b0);
        write_entry(2, 16'd0, 16'd180, 16'd500, 16'd2500, 4'd7, 1'b0);
        set_angle(2, 16'd90);
        set_angle(2, 16'd200);
        write_entry(3, 16'd20, 16'd200, 16'd1500, 16'd1500, 4'd8, 1'b1);
        set_angle(3, 16'd5);
        home_all();
        drain_results();
    endtask

    task automatic test_count_limits();
        write_cfg(sap_pkg::CFG_SERVO_COUNT, 16'd4);
        write_cfg(sap_pkg::CFG_PWM_PERIOD, 16'd1);
        cmd_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        set_pulse(4, 16'd1500);
        set_pulse(15, 16'd1500);
        set_angle(15, 16'd45);
        write_entry(15, 16'd0, 16'd270, 16'd600, 16'd2400, 4'd12, 1'b1);
        write_entry(1, 16'd0, 16'd90, 16'd1000, 16'd2000, 4'd3, 1'b1);
        home_all();
        drain_results();
    endtask

    task automatic run_random_phase(int unsigned count, logic [15:0] period,
                                    int unsigned items, bit fill, bit hold_midway);
        write_cfg(sap_pkg::CFG_SERVO_COUNT, 16'(count));
        write_cfg(sap_pkg::CFG_PWM_PERIOD, period);
        if (fill)
        begin
            for (int i = 0; i < sap_pkg::MAX_SERVOS_DEF; i++)
            begin
                send_random_cmd(i);
            end
        end
        for (int unsigned i = 0; i < items; i++)
        begin
            // switch idling on and off in stretches
            if (i % 12 == 0)
            begin
                cmd_gaps_on   = ($urandom_range(0, 2) != 0);
                rsp_stalls_on = ($urandom_range(0, 2) != 0);
            end
            if (hold_midway && i == items / 2)
            begin
                drain_results();
            end
            send_random_cmd(-1);
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(16, 16'($urandom_range(1, 65535)), 30, 1'b1, 1'b1);
        run_random_phase(1, 16'hFFFF, 35, 1'b0, 1'b0);
        run_random_phase($urandom_range(2, 15), 16'($urandom_range(1, 65535)), 40,
                         1'b0, 1'b0);
        run_random_phase(0, 16'd1, 20, 1'b0, 1'b0);
        run_random_phase(16, 16'($urandom_range(1, 65535)), 55, 1'b1, 1'b0);
    endtask

    // ---------------- main sequence ----------------

    initial
    begin
        for (int i = 0; i < sap_pkg::MAX_SERVOS_DEF; i++)
        begin
            servo_tbl[i] = '0;
        end
        period_cfg = sap_pkg::PWM_PERIOD_RST;
        count_cfg  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_entry_limits();
        test_count_limits();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d commands (write %0d, angle %0d, pulse %0d, home %0d)",
                 cmds_sent, func_seen[sap_pkg::FUNC_WRITE], func_seen[sap_pkg::FUNC_ANGLE],
                 func_seen[sap_pkg::FUNC_PULSE], func_seen[sap_pkg::FUNC_HOME]);
        $display("%0d results checked, %0d register writes, %0d mismatches",
                 results_checked, cfg_writes, fail_count);
        if (fail_count == 0)
        begin
            $display("servo_angle_to_pulse regression: pass");
        end
        else
        begin
            $display("servo_angle_to_pulse regression: fail");
        end
        $finish;
    end

endmodule
